// ===== hdl/bpa_pkg.sv =====
// Buddy page allocator: shared constants, codes and memory word types.
// Depends on nothing; every other file of the block but bpa_ram uses it.
`timescale 1ns / 1ps
package bpa_pkg;
   localparam int MAX_PAGES   = 1024;
   localparam int ORDER_COUNT = 11;
   localparam int PAGE_W      = $clog2(MAX_PAGES);
   localparam int CNT_W       = PAGE_W + 1;
   localparam int ORD_W       = 4;
   localparam int ORDSEL_W    = $clog2(ORDER_COUNT);
   localparam int STATUS_W    = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

   typedef struct packed {
      logic             mark;
      logic [ORD_W-1:0] order;
   } meta_type;

   typedef struct packed {
      logic [PAGE_W-1:0] next;
      logic [PAGE_W-1:0] prev;
   } link_type;

   typedef struct packed {
      logic              we;
      logic [PAGE_W-1:0] wa;
      meta_type          wd;
      logic [PAGE_W-1:0] ra;
   } meta_req_type;

   typedef struct packed {
      logic              we;
      logic [PAGE_W-1:0] wa;
      link_type          wd;
      logic [PAGE_W-1:0] ra;
   } link_req_type;
endpackage

// ===== hdl/bpa_if.sv =====
// Buddy page allocator: request and response channel interfaces.
// Depends on bpa_pkg for field widths.
`timescale 1ns / 1ps
interface bpa_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [bpa_pkg::ORD_W-1:0] alloc_order;
   logic [9:0]                page_index;
   modport source (output valid, operation, alloc_order, page_index, input ready);
   modport sink   (input valid, operation, alloc_order, page_index, output ready);
endinterface

interface bpa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bpa_pkg::STATUS_W-1:0] status;
   logic [9:0]                   block_start;
   logic [bpa_pkg::ORD_W-1:0]    block_order;
   modport source (output valid, status, block_start, block_order, input ready);
   modport sink   (input valid, status, block_start, block_order, output ready);
endinterface

// ===== hdl/bpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/bpa_ctrl.sv =====
// Buddy page allocator sequencer: search, unlink, split, merge and push steps
// over the page metadata and link memories. Depends on bpa_pkg, bpa_if.
`timescale 1ns / 1ps
module bpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [bpa_pkg::CNT_W-1:0] pool_size,
   bpa_req_if.sink               req_chan,
   bpa_rsp_if.source             rsp_chan,
   output bpa_pkg::meta_req_type meta_req,
   input  bpa_pkg::meta_type     meta_rd,
   output bpa_pkg::link_req_type link_req,
   input  bpa_pkg::link_type     link_rd
);
   import bpa_pkg::*;

   typedef enum logic [20:0] {
      ST_CLEAR   = 21'd1 << 0,
      ST_IDLE    = 21'd1 << 1,
      ST_F_CHK   = 21'd1 << 2,
      ST_F_LOOP  = 21'd1 << 3,
      ST_F_BCHK  = 21'd1 << 4,
      ST_F_MERGE = 21'd1 << 5,
      ST_A_SPLIT = 21'd1 << 6,
      ST_U_RD    = 21'd1 << 7,
      ST_U_META  = 21'd1 << 8,
      ST_U_LINK  = 21'd1 << 9,
      ST_U_WPR   = 21'd1 << 10,
      ST_U_RN    = 21'd1 << 11,
      ST_U_WN    = 21'd1 << 12,
      ST_U_CLR   = 21'd1 << 13,
      ST_P_START = 21'd1 << 14,
      ST_P_F     = 21'd1 << 15,
      ST_P_RL    = 21'd1 << 16,
      ST_P_WL    = 21'd1 << 17,
      ST_P_RF    = 21'd1 << 18,
      ST_P_WF    = 21'd1 << 19,
      ST_DONE    = 21'd1 << 20
   } state_type;

   typedef enum logic [1:0] {
      RET_ALLOC,
      RET_MERGE,
      RET_DONE
   } ret_type;

   state_type            state_ff, state_in;
   ret_type              ret_ff, ret_in;
   logic [ORD_W-1:0]     req_ff, req_in;
   logic [ORD_W-1:0]     cur_ff, cur_in;
   logic [PAGE_W-1:0]    p_ff, p_in;
   logic [ORD_W-1:0]     o_ff, o_in;
   logic [PAGE_W-1:0]    b_ff, b_in;
   logic [PAGE_W-1:0]    u_ff, u_in;
   logic [ORD_W-1:0]     uo_ff, uo_in;
   logic [PAGE_W-1:0]    n_ff, n_in;
   logic [PAGE_W-1:0]    pr_ff, pr_in;
   logic [CNT_W-1:0]     pp_ff, pp_in;
   logic [ORD_W-1:0]     po_ff, po_in;
   logic [PAGE_W-1:0]    f_ff, f_in;
   logic [PAGE_W-1:0]    last_ff, last_in;
   logic [PAGE_W-1:0]    cnt_ff, cnt_in;
   logic [PAGE_W-1:0]    first_ff [ORDER_COUNT];
   logic [PAGE_W-1:0]    first_in [ORDER_COUNT];
   logic [ORDER_COUNT-1:0] nonempty_ff, nonempty_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [PAGE_W-1:0]    res_start_ff, res_start_in;
   logic [ORD_W-1:0]     res_order_ff, res_order_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]    rsp_start_ff, rsp_start_in;
   logic [ORD_W-1:0]     rsp_order_ff, rsp_order_in;

   logic                 found;
   logic [ORD_W-1:0]     found_idx;
   logic [PAGE_W-1:0]    buddy;
   logic [ORD_W-1:0]     order_dec;

   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int i = 0; i < ORDER_COUNT; i++) begin
         if (!found && nonempty_ff[i] && (ORD_W'(i) >= req_chan.alloc_order)) begin
            found     = 1'b1;
            found_idx = ORD_W'(i);
         end
      end
   end

   assign buddy     = p_ff ^ (PAGE_W'(1) << o_ff);
   assign order_dec = cur_ff - ORD_W'(1);

   function automatic state_type ret_state(input ret_type r);
      state_type s;
      case (r)
         RET_ALLOC: s = ST_A_SPLIT;
         RET_MERGE: s = ST_F_MERGE;
         default:   s = ST_DONE;
      endcase
      return s;
   endfunction

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      req_in        = req_ff;
      cur_in        = cur_ff;
      p_in          = p_ff;
      o_in          = o_ff;
      b_in          = b_ff;
      u_in          = u_ff;
      uo_in         = uo_ff;
      n_in          = n_ff;
      pr_in         = pr_ff;
      pp_in         = pp_ff;
      po_in         = po_ff;
      f_in          = f_ff;
      last_in       = last_ff;
      cnt_in        = cnt_ff;
      first_in      = first_ff;
      nonempty_in   = nonempty_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_order_in  = res_order_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_order_in  = rsp_order_ff;
      meta_req      = '0;
      link_req      = '0;

      case (state_ff)
         ST_CLEAR: begin
            meta_req.we = 1'b1;
            meta_req.wa = cnt_ff;
            cnt_in      = cnt_ff + PAGE_W'(1);
            if (cnt_ff == PAGE_W'(MAX_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            meta_req.ra = req_chan.page_index;
            if (req_chan.valid) begin
               res_status_in = STATUS_OK;
               res_start_in  = '0;
               res_order_in  = '0;
               if (req_chan.operation == OP_ALLOC) begin
                  if (req_chan.alloc_order >= ORD_W'(ORDER_COUNT)) begin
                     res_status_in = STATUS_RANGE;
                     state_in      = ST_DONE;
                  end else if (!found) begin
                     res_status_in = STATUS_NOFREE;
                     state_in      = ST_DONE;
                  end else begin
                     req_in   = req_chan.alloc_order;
                     cur_in   = found_idx;
                     p_in     = first_ff[found_idx];
                     u_in     = first_ff[found_idx];
                     ret_in   = RET_ALLOC;
                     state_in = ST_U_RD;
                  end
               end else begin
                  if ({1'b0, req_chan.page_index} >= pool_size) begin
                     res_status_in = STATUS_RANGE;
                     state_in      = ST_DONE;
                  end else begin
                     p_in     = req_chan.page_index;
                     state_in = ST_F_CHK;
                  end
               end
            end
         end
         ST_F_CHK: begin
            if (meta_rd.mark) begin
               res_status_in = STATUS_RANGE;
               state_in      = ST_DONE;
            end else begin
               o_in     = (meta_rd.order >= ORD_W'(ORDER_COUNT)) ?
                          ORD_W'(ORDER_COUNT - 1) : meta_rd.order;
               state_in = ST_F_LOOP;
            end
         end
         ST_F_LOOP: begin
            meta_req.ra = buddy;
            if (o_ff >= ORD_W'(ORDER_COUNT - 1) || {1'b0, buddy} >= pool_size) begin
               pp_in        = {1'b0, p_ff};
               po_in        = o_ff;
               ret_in       = RET_DONE;
               res_start_in = p_ff;
               res_order_in = o_ff;
               state_in     = ST_P_START;
            end else begin
               b_in     = buddy;
               state_in = ST_F_BCHK;
            end
         end
         ST_F_BCHK: begin
            if (!meta_rd.mark || meta_rd.order != o_ff) begin
               pp_in        = {1'b0, p_ff};
               po_in        = o_ff;
               ret_in       = RET_DONE;
               res_start_in = p_ff;
               res_order_in = o_ff;
               state_in     = ST_P_START;
            end else begin
               u_in     = b_ff;
               ret_in   = RET_MERGE;
               state_in = ST_U_RD;
            end
         end
         ST_F_MERGE: begin
            p_in     = p_ff & ~(PAGE_W'(1) << o_ff);
            o_in     = o_ff + ORD_W'(1);
            state_in = ST_F_LOOP;
         end
         ST_A_SPLIT: begin
            if (cur_ff > req_ff) begin
               cur_in   = order_dec;
               pp_in    = {1'b0, p_ff} + (CNT_W'(1) << order_dec);
               po_in    = order_dec;
               ret_in   = RET_ALLOC;
               state_in = ST_P_START;
            end else begin
               meta_req.we    = 1'b1;
               meta_req.wa    = p_ff;
               meta_req.wd    = '{mark: 1'b0, order: req_ff};
               res_start_in   = p_ff;
               res_order_in   = req_ff;
               state_in       = ST_DONE;
            end
         end
         ST_U_RD: begin
            meta_req.ra = u_ff;
            state_in    = ST_U_META;
         end
         ST_U_META: begin
            link_req.ra = u_ff;
            uo_in       = meta_rd.order;
            if (meta_rd.order < ORD_W'(ORDER_COUNT) && meta_rd.mark &&
                nonempty_ff[ORDSEL_W'(meta_rd.order)]) begin
               state_in = ST_U_LINK;
            end else begin
               state_in = ST_U_CLR;
            end
         end
         ST_U_LINK: begin
            link_req.ra = link_rd.prev;
            if (link_rd.next == u_ff) begin
               nonempty_in[ORDSEL_W'(uo_ff)] = 1'b0;
               state_in = ST_U_CLR;
            end else begin
               n_in  = link_rd.next;
               pr_in = link_rd.prev;
               if (first_ff[ORDSEL_W'(uo_ff)] == u_ff) begin
                  first_in[ORDSEL_W'(uo_ff)] = link_rd.next;
               end
               state_in = ST_U_WPR;
            end
         end
         ST_U_WPR: begin
            link_req.we = 1'b1;
            link_req.wa = pr_ff;
            link_req.wd = '{next: n_ff, prev: link_rd.prev};
            state_in    = ST_U_RN;
         end
         ST_U_RN: begin
            link_req.ra = n_ff;
            state_in    = ST_U_WN;
         end
         ST_U_WN: begin
            link_req.we = 1'b1;
            link_req.wa = n_ff;
            link_req.wd = '{next: link_rd.next, prev: pr_ff};
            state_in    = ST_U_CLR;
         end
         ST_U_CLR: begin
            meta_req.we = 1'b1;
            meta_req.wa = u_ff;
            state_in    = ret_state(ret_ff);
         end
         ST_P_START: begin
            link_req.ra = first_ff[ORDSEL_W'(po_ff)];
            if (pp_ff >= CNT_W'(MAX_PAGES)) begin
               state_in = ret_state(ret_ff);
            end else begin
               meta_req.we = 1'b1;
               meta_req.wa = pp_ff[PAGE_W-1:0];
               meta_req.wd = '{mark: 1'b1, order: po_ff};
               if (!nonempty_ff[ORDSEL_W'(po_ff)]) begin
                  link_req.we = 1'b1;
                  link_req.wa = pp_ff[PAGE_W-1:0];
                  link_req.wd = '{next: pp_ff[PAGE_W-1:0], prev: pp_ff[PAGE_W-1:0]};
                  nonempty_in[ORDSEL_W'(po_ff)] = 1'b1;
                  first_in[ORDSEL_W'(po_ff)]    = pp_ff[PAGE_W-1:0];
                  state_in = ret_state(ret_ff);
               end else begin
                  f_in     = first_ff[ORDSEL_W'(po_ff)];
                  state_in = ST_P_F;
               end
            end
         end
         ST_P_F: begin
            last_in     = link_rd.prev;
            link_req.we = 1'b1;
            link_req.wa = pp_ff[PAGE_W-1:0];
            link_req.wd = '{next: f_ff, prev: link_rd.prev};
            state_in    = ST_P_RL;
         end
         ST_P_RL: begin
            link_req.ra = last_ff;
            state_in    = ST_P_WL;
         end
         ST_P_WL: begin
            link_req.we = 1'b1;
            link_req.wa = last_ff;
            link_req.wd = '{next: pp_ff[PAGE_W-1:0], prev: link_rd.prev};
            state_in    = ST_P_RF;
         end
         ST_P_RF: begin
            link_req.ra = f_ff;
            state_in    = ST_P_WF;
         end
         ST_P_WF: begin
            link_req.we = 1'b1;
            link_req.wa = f_ff;
            link_req.wd = '{next: link_rd.next, prev: pp_ff[PAGE_W-1:0]};
            first_in[ORDSEL_W'(po_ff)] = pp_ff[PAGE_W-1:0];
            state_in = ret_state(ret_ff);
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_order_in  = res_order_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         ret_ff       <= RET_DONE;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
         ret_ff       <= ret_in;
      end
      req_ff        <= req_in;
      cur_ff        <= cur_in;
      p_ff          <= p_in;
      o_ff          <= o_in;
      b_ff          <= b_in;
      u_ff          <= u_in;
      uo_ff         <= uo_in;
      n_ff          <= n_in;
      pr_ff         <= pr_in;
      pp_ff         <= pp_in;
      po_ff         <= po_in;
      f_ff          <= f_in;
      last_ff       <= last_in;
      first_ff      <= first_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_order_ff  <= res_order_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_order_ff  <= rsp_order_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.block_start = rsp_start_ff;
   assign rsp_chan.block_order = rsp_order_ff;
endmodule

// ===== hdl/buddy_page_allocator.sv =====
// Buddy page allocator top level: pool size register, metadata and link RAMs,
// sequencer. Depends on bpa_pkg, bpa_if, bpa_ram, bpa_ctrl.
//
// One request at a time. After reset the block sweeps the page metadata RAM
// with req ready low; csr writes are taken throughout. No page is free after
// reset, so software frees every page once. An allocate unlinks the head of
// the smallest non-empty list that fits, then halves the block down to the
// requested order, pushing each upper half onto its free list. A free checks
// the page, merges with its buddy while the buddy is free at the same order,
// then pushes the result. Each step is bounded by the single read port of the
// link RAM, and a free can merge through all ten levels. A finished response
// waits in its register while the next request is taken.
`timescale 1ns / 1ps
module buddy_page_allocator (
   input  logic                      clock,
   input  logic                      reset,
   bpa_req_if.sink                   req_chan,
   bpa_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [bpa_pkg::CNT_W-1:0] csr_wr_data
);
   import bpa_pkg::*;

   logic [CNT_W-1:0] page_count_ff, page_count_in;
   logic [CNT_W-1:0] pool_size;
   meta_req_type     meta_req;
   link_req_type     link_req;
   logic [$bits(meta_type)-1:0] meta_rd_bits;
   logic [$bits(link_type)-1:0] link_rd_bits;

   assign page_count_in = csr_wr_en ? csr_wr_data : page_count_ff;
   assign pool_size     = (page_count_ff > CNT_W'(MAX_PAGES)) ?
                          CNT_W'(MAX_PAGES) : page_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= CNT_W'(MAX_PAGES);
      end else begin
         page_count_ff <= page_count_in;
      end
   end

   bpa_ram #(.WIDTH($bits(meta_type)), .DEPTH(MAX_PAGES)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_req.we),
      .wr_addr (meta_req.wa),
      .wr_data (meta_req.wd),
      .rd_addr (meta_req.ra),
      .rd_data (meta_rd_bits)
   );

   bpa_ram #(.WIDTH($bits(link_type)), .DEPTH(MAX_PAGES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_req.we),
      .wr_addr (link_req.wa),
      .wr_data (link_req.wd),
      .rd_addr (link_req.ra),
      .rd_data (link_rd_bits)
   );

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .pool_size (pool_size),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .meta_req  (meta_req),
      .meta_rd   (meta_type'(meta_rd_bits)),
      .link_req  (link_req),
      .link_rd   (link_type'(link_rd_bits))
   );
endmodule

// ===== hdl/bpa_checker.sv =====
// Port-level checks for the buddy page allocator, bound to the top level.
// Depends on bpa_pkg.
`timescale 1ns / 1ps
module bpa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bpa_pkg::STATUS_W-1:0] rsp_status,
   input logic [9:0]                   rsp_block_start,
   input logic [bpa_pkg::ORD_W-1:0]    rsp_block_order
);
   import bpa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_block_start) && $stable(rsp_block_order))
      else $error("response beat changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_block_start == '0 &&
      rsp_block_order == '0)
      else $error("error response carries a block");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_NOFREE ||
      rsp_status == STATUS_RANGE)
      else $error("undefined status code");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ports active right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken before the first finished");
endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_block_start (rsp_chan.block_start),
   .rsp_block_order (rsp_chan.block_order)
);
